// ----- sv/levp_pkg.sv -----
package levp_pkg;

    localparam int MAX_VECTORS = 64;
    localparam int POS_W       = $clog2(MAX_VECTORS + 1);
    localparam int IDX_W       = $clog2(MAX_VECTORS);
    localparam int OUT_IDX_W   = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_REF_ROW        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH_SQ  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COLUMN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_REACH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_REACH    = 3'd4;

    localparam logic [7:0]  RST_REF_ROW        = 8'd40;
    localparam logic [16:0] RST_MIN_LENGTH_SQ  = 17'd100;
    localparam logic [7:0]  RST_CENTER_COLUMN  = 8'd39;
    localparam logic [7:0]  RST_OUTER_REACH    = 8'd35;
    localparam logic [7:0]  RST_INNER_REACH    = 8'd10;

    typedef struct packed {
        logic [7:0] start_col;
        logic [7:0] start_row;
        logic [7:0] end_col;
        logic [7:0] end_row;
        logic       frame_last;
    } t_in_word;

    typedef struct packed {
        logic                 left_found;
        logic [OUT_IDX_W-1:0] left_index;
        logic                 right_found;
        logic [OUT_IDX_W-1:0] right_index;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  ref_row;
        logic [16:0] min_length_sq;
        logic [7:0]  center_column;
        logic [7:0]  outer_reach;
        logic [7:0]  inner_reach;
    } t_cfg;

    typedef struct packed {
        logic       left_hit;
        logic       right_hit;
        logic [7:0] near_row;
    } t_cand;

endpackage

// ----- sv/lane_edge_vector_picker_core.sv -----
// the last word of a frame is held in r_s1, then its result word in r_out
// one word per cycle, set by the single input register and evaluator, unless
// a stalled result holds back a last word, and with it all following words
// reset (synchronous, active low) clears the frame state and loads the
// register defaults; the block takes words as soon as reset is released
module lane_edge_vector_picker_core
    import levp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       r_cfg;
    t_in_word   r_s1;
    logic       r_s1_valid;
    t_out_word  r_out;
    logic       r_out_valid;
    logic [POS_W-1:0] r_pos;
    logic       r_left_valid, r_right_valid;
    logic [7:0] r_left_row, r_right_row;
    logic [IDX_W-1:0] r_left_idx, r_right_idx;

    logic [POS_W-1:0] n_pos;
    logic       n_left_valid, n_right_valid;
    logic [7:0] n_left_row, n_right_row;
    logic [IDX_W-1:0] n_left_idx, n_right_idx;
    t_out_word  n_out;

    t_cand      cand;
    logic       s1_go, in_accept, in_range, upd_left, upd_right;

    levp_eval u_eval (
        .i_word (r_s1),
        .i_cfg  (r_cfg),
        .o_cand (cand)
    );

    assign o_cfg_ready = 1'b1;
    assign s1_go       = r_s1_valid && (!r_s1.frame_last || !r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !s1_go;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign in_range    = r_pos < POS_W'(MAX_VECTORS);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        upd_left  = s1_go && in_range && cand.left_hit &&
                    (!r_left_valid || cand.near_row > r_left_row);
        upd_right = s1_go && in_range && cand.right_hit &&
                    (!r_right_valid || cand.near_row > r_right_row);

        n_left_valid  = r_left_valid | upd_left;
        n_left_row    = upd_left ? cand.near_row : r_left_row;
        n_left_idx    = upd_left ? r_pos[IDX_W-1:0] : r_left_idx;
        n_right_valid = r_right_valid | upd_right;
        n_right_row   = upd_right ? cand.near_row : r_right_row;
        n_right_idx   = upd_right ? r_pos[IDX_W-1:0] : r_right_idx;
        n_pos         = (s1_go && in_range) ? r_pos + POS_W'(1) : r_pos;

        n_out.left_found  = n_left_valid;
        n_out.left_index  = n_left_valid ? OUT_IDX_W'(n_left_idx) : '0;
        n_out.right_found = n_right_valid;
        n_out.right_index = n_right_valid ? OUT_IDX_W'(n_right_idx) : '0;

        // end of frame
        if (s1_go && r_s1.frame_last) begin
            n_pos         = '0;
            n_left_valid  = 1'b0;
            n_left_row    = '0;
            n_left_idx    = '0;
            n_right_valid = 1'b0;
            n_right_row   = '0;
            n_right_idx   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_row        <= RST_REF_ROW;
            r_cfg.min_length_sq  <= RST_MIN_LENGTH_SQ;
            r_cfg.center_column  <= RST_CENTER_COLUMN;
            r_cfg.outer_reach    <= RST_OUTER_REACH;
            r_cfg.inner_reach    <= RST_INNER_REACH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_REF_ROW:        r_cfg.ref_row        <= i_cfg_data[7:0];
                CFG_MIN_LENGTH_SQ:  r_cfg.min_length_sq  <= i_cfg_data[16:0];
                CFG_CENTER_COLUMN:  r_cfg.center_column  <= i_cfg_data[7:0];
                CFG_OUTER_REACH:    r_cfg.outer_reach    <= i_cfg_data[7:0];
                CFG_INNER_REACH:    r_cfg.inner_reach    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_pos         <= '0;
            r_left_valid  <= 1'b0;
            r_left_row    <= '0;
            r_left_idx    <= '0;
            r_right_valid <= 1'b0;
            r_right_row   <= '0;
            r_right_idx   <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go && r_s1.frame_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_pos         <= n_pos;
            r_left_valid  <= n_left_valid;
            r_left_row    <= n_left_row;
            r_left_idx    <= n_left_idx;
            r_right_valid <= n_right_valid;
            r_right_row   <= n_right_row;
            r_right_idx   <= n_right_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= i_in_data;
        end
        if (s1_go && r_s1.frame_last) begin
            r_out <= n_out;
        end
    end

    // position counter saturates at the frame limit
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_VECTORS))
        else $error("position counter beyond frame limit");

    // a closed frame leaves a result and a cleared state
    a_frame_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_s1.frame_last |=> r_out_valid && r_pos == '0 &&
                                      !r_left_valid && !r_right_valid)
        else $error("frame close did not clear state or post result");

    // no back pressure while the input register is empty
    a_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("stall with empty input register");

    // a side not found reports index zero
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (!r_out.left_found || !r_out.right_found) |->
            (r_out.left_found || r_out.left_index == '0) &&
            (r_out.right_found || r_out.right_index == '0))
        else $error("nonzero index without found flag");

    // a word never matches both sides
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> !(cand.left_hit && cand.right_hit))
        else $error("candidate classified on both sides");

endmodule

// ----- sv/levp_eval.sv -----
module levp_eval
    import levp_pkg::*;
(
    input  t_in_word i_word,
    input  t_cfg     i_cfg,
    output t_cand    o_cand
);

    logic signed [9:0]  dx, dy, rel, sd, sx0, sc, smx, smn;
    logic signed [19:0] dx_sq, dy_sq, num, p;
    logic signed [19:0] c_d, lo_l, hi_l, hi_r, lo_r;
    logic [17:0]        len_sq;
    logic [7:0]         d;
    logic               long_enough, spans, keep;

    always_comb begin
        dx    = $signed({2'b00, i_word.end_col}) - $signed({2'b00, i_word.start_col});
        dy    = $signed({2'b00, i_word.end_row}) - $signed({2'b00, i_word.start_row});
        rel   = $signed({2'b00, i_cfg.ref_row}) - $signed({2'b00, i_word.start_row});
        dx_sq = 20'(dx) * 20'(dx);
        dy_sq = 20'(dy) * 20'(dy);
        len_sq = 18'(dx_sq) + 18'(dy_sq);
        long_enough = len_sq >= {1'b0, i_cfg.min_length_sq};
        spans = (i_cfg.ref_row >= i_word.start_row && i_cfg.ref_row <= i_word.end_row) ||
                (i_cfg.ref_row >= i_word.end_row && i_cfg.ref_row <= i_word.start_row);
        keep  = long_enough && spans;

        // flat segment on the row: rel is zero, so p reduces to start_col
        if (dy == 10'sd0) begin
            d = 8'd1;
        end else if (dy < 10'sd0) begin
            d = 8'(-dy);
        end else begin
            d = 8'(dy);
        end
        sd  = $signed({2'b00, d});
        sx0 = $signed({2'b00, i_word.start_col});
        num = 20'(rel) * 20'(dx);
        if (dy < 10'sd0) begin
            num = -num;
        end
        p = 20'(sx0) * 20'(sd) + num;

        sc   = $signed({2'b00, i_cfg.center_column});
        smx  = $signed({2'b00, i_cfg.outer_reach});
        smn  = $signed({2'b00, i_cfg.inner_reach});
        c_d  = 20'(sc) * 20'(sd);
        lo_l = 20'(sc - smx) * 20'(sd);
        hi_l = 20'(sc - smn) * 20'(sd);
        hi_r = 20'(sc + smx) * 20'(sd);
        lo_r = 20'(sc + smn) * 20'(sd);

        o_cand.left_hit  = keep && (p < c_d) && (p >= lo_l) && (p <= hi_l);
        o_cand.right_hit = keep && (p >= c_d) && (p <= hi_r) && (p >= lo_r);
        o_cand.near_row  = (i_word.start_row > i_word.end_row) ? i_word.start_row
                                                                : i_word.end_row;
    end

endmodule

// ----- test/lane_edge_vector_picker_core_test.sv -----
module lane_edge_vector_picker_core_test;
    import levp_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_WORDS  = 150;
    localparam int PHASES       = 7;
    localparam int DIR_ROWS     = 23;

    typedef struct packed {
        t_in_word  w;
        logic      typed;
        t_out_word want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_word              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_word             o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    t_cfg        cfg_q;
    t_out_word   picks_q[$];
    int          err_cnt;
    bit          no_idle;
    bit          hold_req;
    bit          typed_now;
    t_out_word   typed_pick;

    int          fr_pos;
    bit          lft_ok, rgt_ok;
    longint      lft_row, rgt_row;
    int          lft_idx, rgt_idx;

    t_dir_row dir_tab [DIR_ROWS] = '{
        '{'{20, 30, 20, 50, 1}, 1, '{1, 0, 0, 0}},
        '{'{60, 20, 60, 60, 0}, 0, '{0, 0, 0, 0}},
        '{'{20, 10, 20, 45, 0}, 0, '{0, 0, 0, 0}},
        '{'{25, 50, 25, 30, 1}, 1, '{1, 2, 1, 0}},
        '{'{20, 38, 25, 42, 1}, 1, '{0, 0, 0, 0}},
        '{'{20, 0, 20, 30, 1}, 1, '{0, 0, 0, 0}},
        '{'{60, 40, 80, 40, 1}, 1, '{0, 0, 1, 0}},
        '{'{60, 41, 80, 41, 1}, 1, '{0, 0, 0, 0}},
        '{'{20, 30, 20, 50, 0}, 0, '{0, 0, 0, 0}},
        '{'{15, 50, 15, 30, 1}, 1, '{1, 0, 0, 0}},
        '{'{3, 30, 3, 50, 1}, 1, '{0, 0, 0, 0}},
        '{'{4, 30, 4, 50, 1}, 1, '{1, 0, 0, 0}},
        '{'{29, 30, 29, 50, 1}, 1, '{1, 0, 0, 0}},
        '{'{30, 30, 30, 50, 1}, 1, '{0, 0, 0, 0}},
        '{'{39, 30, 39, 50, 1}, 1, '{0, 0, 0, 0}},
        '{'{49, 30, 49, 50, 1}, 1, '{0, 0, 1, 0}},
        '{'{74, 30, 74, 50, 1}, 1, '{0, 0, 1, 0}},
        '{'{75, 30, 75, 50, 1}, 1, '{0, 0, 0, 0}},
        '{'{0, 0, 255, 255, 1}, 0, '{0, 0, 0, 0}},
        '{'{255, 255, 0, 0, 1}, 0, '{0, 0, 0, 0}},
        '{'{10, 20, 30, 60, 0}, 0, '{0, 0, 0, 0}},
        '{'{100, 60, 50, 0, 0}, 0, '{0, 0, 0, 0}},
        '{'{60, 255, 60, 0, 1}, 0, '{0, 0, 0, 0}}
    };

    lane_edge_vector_picker_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic int clip8(int v);
        return v < 0 ? 0 : (v > 255 ? 255 : v);
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int frame_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return $urandom_range(64, 70);
        if (r < 20) return $urandom_range(9, 24);
        return $urandom_range(1, 8);
    endfunction

    // mostly segments that straddle the reference row near the lane window
    function automatic t_in_word make_segment(bit last);
        t_in_word w;
        int r, ref_r, span, base, a, b;
        r = $urandom_range(0, 99);
        ref_r = int'(cfg_q.ref_row);
        if (r < 30) begin
            {w.start_col, w.start_row, w.end_col, w.end_row} = $urandom;
        end else begin
            a = int'($urandom_range(0, ref_r));
            b = int'($urandom_range(ref_r, 255));
            if (r < 40) begin
                a = ref_r;
                b = ref_r;
            end
            span = int'(cfg_q.outer_reach) + 8;
            base = clip8(int'(cfg_q.center_column) + int'($urandom_range(0, 2 * span)) - span);
            w.start_col = 8'(base);
            w.end_col   = 8'(clip8(base + int'($urandom_range(0, 40)) - 20));
            if ($urandom_range(0, 1) == 1) begin
                w.start_row = 8'(a);
                w.end_row   = 8'(b);
            end else begin
                w.start_row = 8'(b);
                w.end_row   = 8'(a);
            end
        end
        w.frame_last = last;
        return w;
    endfunction

    // running edge choice for the current frame
    function automatic void advance_frame(input t_in_word w, output bit done,
                                          output t_out_word res);
        longint x0, y0, x1, y1, dx, dy, r, c, mx, mn, p, d, near_row;
        bit keep;
        x0 = longint'(w.start_col);
        y0 = longint'(w.start_row);
        x1 = longint'(w.end_col);
        y1 = longint'(w.end_row);
        r  = longint'(cfg_q.ref_row);
        c  = longint'(cfg_q.center_column);
        mx = longint'(cfg_q.outer_reach);
        mn = longint'(cfg_q.inner_reach);
        done = 1'b0;
        res  = '0;
        if (fr_pos < MAX_VECTORS) begin
            dx = x1 - x0;
            dy = y1 - y0;
            keep = (dx * dx + dy * dy >= longint'(cfg_q.min_length_sq)) &&
                   ((r >= y0 && r <= y1) || (r >= y1 && r <= y0));
            if (keep) begin
                if (dy == 0) begin
                    p = x0;
                    d = 1;
                end else begin
                    d = dy < 0 ? -dy : dy;
                    p = x0 * d + (dy < 0 ? -((r - y0) * dx) : (r - y0) * dx);
                end
                near_row = y0 > y1 ? y0 : y1;
                if (p < c * d) begin
                    if (p >= (c - mx) * d && p <= (c - mn) * d &&
                        (!lft_ok || near_row > lft_row)) begin
                        lft_ok  = 1'b1;
                        lft_row = near_row;
                        lft_idx = fr_pos;
                    end
                end else if (p <= (c + mx) * d && p >= (c + mn) * d &&
                             (!rgt_ok || near_row > rgt_row)) begin
                    rgt_ok  = 1'b1;
                    rgt_row = near_row;
                    rgt_idx = fr_pos;
                end
            end
            fr_pos++;
        end
        if (w.frame_last) begin
            done = 1'b1;
            res.left_found  = lft_ok;
            res.left_index  = lft_ok ? OUT_IDX_W'(lft_idx) : '0;
            res.right_found = rgt_ok;
            res.right_index = rgt_ok ? OUT_IDX_W'(rgt_idx) : '0;
            fr_pos  = 0;
            lft_ok  = 1'b0;
            lft_row = 0;
            lft_idx = 0;
            rgt_ok  = 1'b0;
            rgt_row = 0;
            rgt_idx = 0;
        end
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t %s expected %0d got %0d", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic send_word(t_in_word w, bit typed, t_out_word want);
        int gap;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        typed_now  = typed;
        typed_pick = want;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_REF_ROW:        cfg_q.ref_row        = 8'(val);
            CFG_MIN_LENGTH_SQ:  cfg_q.min_length_sq  = 17'(val);
            CFG_CENTER_COLUMN:  cfg_q.center_column  = 8'(val);
            CFG_OUTER_REACH:    cfg_q.outer_reach    = 8'(val);
            CFG_INNER_REACH:    cfg_q.inner_reach    = 8'(val);
            default: ;
        endcase
    endtask

    // drain: no word offered, all picks back, pipeline empty
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (picks_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        bit        got;
        t_out_word res;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            advance_frame(i_in_data, got, res);
            if (got) picks_q.push_back(typed_now ? typed_pick : res);
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (picks_q.size() == 0) begin
                $display("%0t unexpected result word %h", $time, o_out_data);
                err_cnt++;
            end else begin
                want = picks_q.pop_front();
                check_field("left_found", want.left_found, o_out_data.left_found);
                check_field("left_index", want.left_index, o_out_data.left_index);
                check_field("right_found", want.right_found, o_out_data.right_found);
                check_field("right_index", want.right_index, o_out_data.right_index);
            end
        end
    end

    initial begin
        int run_left, hold_left;
        i_out_stall = 1'b0;
        run_left    = 0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (no_idle) begin
                i_out_stall <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
            end else if (i_out_stall) begin
                i_out_stall <= 1'b0;
                run_left = $urandom_range(0, 10);
            end else begin
                i_out_stall <= 1'b1;
                run_left = idle_len();
            end
        end
    end

    initial begin
        #(12 * 1000000);
        $display("[lane_edge_vector_picker_core] ERROR");
        $finish;
    end

    initial begin
        int v_ref, v_len, v_ctr, v_max, v_min, sent, n;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        err_cnt     = 0;
        no_idle     = 1'b0;
        hold_req    = 1'b0;
        typed_now   = 1'b0;
        typed_pick  = '0;
        fr_pos      = 0;
        lft_ok      = 1'b0;
        lft_row     = 0;
        lft_idx     = 0;
        rgt_ok      = 1'b0;
        rgt_row     = 0;
        rgt_idx     = 0;
        cfg_q = '{RST_REF_ROW, RST_MIN_LENGTH_SQ, RST_CENTER_COLUMN,
                  RST_OUTER_REACH, RST_INNER_REACH};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_ROWS; k++)
            send_word(dir_tab[k].w, dir_tab[k].typed, dir_tab[k].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    v_ref = 0; v_len = 0; v_ctr = 0; v_max = 255; v_min = 0;
                end
                1: begin
                    v_ref = 255; v_len = 130050; v_ctr = 255; v_max = 255; v_min = 255;
                end
                3: begin
                    // crossed half-widths
                    v_ref = $urandom_range(0, 255);
                    v_len = $urandom_range(0, 400);
                    v_ctr = $urandom_range(0, 255);
                    v_min = $urandom_range(1, 255);
                    v_max = $urandom_range(0, v_min - 1);
                end
                default: begin
                    v_ref = $urandom_range(0, 255);
                    v_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 130050)
                                                        : $urandom_range(0, 2000);
                    v_ctr = $urandom_range(0, 255);
                    v_max = $urandom_range(0, 255);
                    v_min = $urandom_range(0, v_max);
                end
            endcase
            write_reg(CFG_REF_ROW, v_ref);
            write_reg(CFG_MIN_LENGTH_SQ, v_len);
            write_reg(CFG_CENTER_COLUMN, v_ctr);
            write_reg(CFG_OUTER_REACH, v_max);
            write_reg(CFG_INNER_REACH, v_min);
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;
            no_idle = (ph == 2);
            if (ph == 4) hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_WORDS) begin
                n = frame_len();
                for (int j = 0; j < n; j++)
                    send_word(make_segment(j == n - 1), 1'b0, '0);
                sent += n;
            end
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("[lane_edge_vector_picker_core] OK");
        end else begin
            $display("[lane_edge_vector_picker_core] ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/levp_pkg.sv
sv/levp_eval.sv
sv/lane_edge_vector_picker_core.sv
test/lane_edge_vector_picker_core_test.sv
